FILE: rtl/core/stmq_pkg.sv
package stmq_pkg;

    // default sizing
    localparam int CAPACITY_DEF   = 1024;
    localparam int LEVELS_DEF     = 11;
    localparam int VALUE_BITS_DEF = 32;

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_APPEND,
        S_QRD2,
        S_QMIN
    } state_t;

    // element count update at the end of an operation
    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_ZERO,
        CNT_INC
    } cnt_op_t;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic       start;
        logic [1:0] opcode;
        logic       full;
        logic       bad_range;
        logic       has_pair;
        logic       more_levels;
    } stmq_cond_t;

    // sequencer controls for the datapath
    typedef struct packed {
        logic       busy;
        logic       load;
        logic       append_init;
        logic       append_read;
        logic       append_step;
        logic       query_first;
        logic       query_second;
        logic       finish;
        logic       take_min;
        logic [1:0] status;
        cnt_op_t    cnt_op;
    } stmq_ctl_t;

endpackage

FILE: rtl/core/stmq_ram.sv
module stmq_ram
    import stmq_pkg::*;
#(
    parameter int WIDTH  = VALUE_BITS_DEF,
    parameter int DEPTH  = LEVELS_DEF * CAPACITY_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/stmq_ctrl.sv
module stmq_ctrl
    import stmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stmq_cond_t cond,
    output stmq_ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cond.start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (cond.opcode == OP_APPEND && !cond.full && cond.has_pair)
                begin
                    state_next = S_APPEND;
                end
                else if (cond.opcode == OP_QUERY && !cond.bad_range)
                begin
                    state_next = S_QRD2;
                end
            end
            S_APPEND:
            begin
                if (!cond.more_levels)
                begin
                    state_next = S_IDLE;
                end
            end
            S_QRD2:
            begin
                state_next = S_QMIN;
            end
            S_QMIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        ctl = '0;
        ctl.status = ST_OK;
        ctl.cnt_op = CNT_KEEP;
        ctl.busy   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.load = cond.start;
            end
            S_EXEC:
            begin
                unique case (cond.opcode)
                    OP_CLEAR:
                    begin
                        ctl.finish = 1'b1;
                        ctl.cnt_op = CNT_ZERO;
                    end
                    OP_APPEND:
                    begin
                        if (cond.full)
                        begin
                            ctl.finish = 1'b1;
                            ctl.status = ST_FULL;
                        end
                        else
                        begin
                            ctl.append_init = 1'b1;
                            if (cond.has_pair)
                            begin
                                ctl.append_read = 1'b1;
                            end
                            else
                            begin
                                ctl.finish = 1'b1;
                                ctl.cnt_op = CNT_INC;
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        if (cond.bad_range)
                        begin
                            ctl.finish = 1'b1;
                            ctl.status = ST_BAD_RANGE;
                        end
                        else
                        begin
                            ctl.query_first = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctl.finish = 1'b1;
                    end
                endcase
            end
            S_APPEND:
            begin
                ctl.append_step = 1'b1;
                if (cond.more_levels)
                begin
                    ctl.append_read = 1'b1;
                end
                else
                begin
                    ctl.finish = 1'b1;
                    ctl.cnt_op = CNT_INC;
                end
            end
            S_QRD2:
            begin
                ctl.query_second = 1'b1;
            end
            S_QMIN:
            begin
                ctl.finish   = 1'b1;
                ctl.take_min = 1'b1;
            end
            default:
            begin
                ctl.busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/sparse_table_range_minimum.sv
// Range minimum over an array loaded one element at a time, kept as a sparse
// table in one single-port-read memory of LEVELS x CAPACITY entries. An item is
// taken when start is high and busy is low; its result appears in the first
// cycle with busy low again, for exactly one cycle with done high, and must be
// captured then since there is no way to hold it. Clear, the unused opcode and a
// rejected item end in the execute state; a query in range goes on through the
// second-read and min states (two reads of the table memory through its one
// read port), and an append at index i fills level 0 in the execute state and
// levels 1 up to min(floor(log2(i+1)), LEVELS-1) in the append state: one table
// level is filled per cycle through the shared min compare. The table needs no
// clearing after reset; stored_count is valid while done is high.
module sparse_table_range_minimum
    import stmq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int LEVELS     = LEVELS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   opcode,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic [$clog2(CAPACITY)-1:0]  left_index,
    input  logic [$clog2(CAPACITY)-1:0]  right_index,
    output logic                         done,
    output logic signed [VALUE_BITS-1:0] minimum,
    output logic [1:0]                   status,
    output logic [$clog2(CAPACITY+1)-1:0] stored_count
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int DEPTH  = LEVELS * CAPACITY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int KW     = $clog2(CNT_W);
    localparam int SPAN_W = ((IDX_W > LEVELS) ? IDX_W : LEVELS) + 1;

    stmq_cond_t cond;
    stmq_ctl_t  ctl;

    // latched item
    logic [1:0]                   opcode_reg, opcode_next;
    logic signed [VALUE_BITS-1:0] value_reg, value_next;
    logic [IDX_W-1:0]             left_reg, left_next;
    logic [IDX_W-1:0]             right_reg, right_next;

    // append walk and shared operand
    logic [LVL_W-1:0]             lvl_reg, lvl_next;
    logic [IDX_W-1:0]             s_reg, s_next;
    logic signed [VALUE_BITS-1:0] carry_reg, carry_next;
    logic [ADDR_W-1:0]            q2_addr_reg, q2_addr_next;

    // element count and result
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         done_reg, done_next;
    logic signed [VALUE_BITS-1:0] min_reg, min_next;
    logic [1:0]                   status_reg, status_next;

    // table memory port signals
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [VALUE_BITS-1:0]        wr_data;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [VALUE_BITS-1:0]        rd_raw;
    logic signed [VALUE_BITS-1:0] rd_data;

    // query decode
    logic [CNT_W-1:0]             q_len;
    logic [KW-1:0]                k_raw;
    logic [LVL_W-1:0]             q_lvl;
    logic [CNT_W-1:0]             second_wide;
    logic [IDX_W-1:0]             second_idx;

    logic [IDX_W-1:0]             s_step;
    logic signed [VALUE_BITS-1:0] min_val;

    function automatic logic [ADDR_W-1:0] tbl_addr(
        input logic [LVL_W-1:0] lvl,
        input logic [IDX_W-1:0] idx
    );
        tbl_addr = ADDR_W'(lvl) * ADDR_W'(CAPACITY) + ADDR_W'(idx);
    endfunction

    stmq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctl   (ctl)
    );

    stmq_ram #(
        .WIDTH  (VALUE_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_data = $signed(rd_raw);

    // shared min unit
    assign min_val = (rd_data < carry_reg) ? rd_data : carry_reg;

    // query level by priority encoder, saturated to the top level
    always_comb
    begin
        q_len = CNT_W'(right_reg) - CNT_W'(left_reg) + CNT_W'(1);
        k_raw = '0;
        for (int b = 0; b < CNT_W; b++)
        begin
            if (q_len[b])
            begin
                k_raw = KW'(b);
            end
        end
        if (int'(k_raw) > LEVELS - 1)
        begin
            q_lvl = LVL_W'(LEVELS - 1);
        end
        else
        begin
            q_lvl = LVL_W'(k_raw);
        end
        second_wide = CNT_W'(right_reg) + CNT_W'(1) - (CNT_W'(1) << q_lvl);
        second_idx  = second_wide[IDX_W-1:0];
    end

    // conditions for the sequencer
    always_comb
    begin
        cond.start       = start;
        cond.opcode      = opcode_reg;
        cond.full        = (count_reg == CNT_W'(CAPACITY));
        cond.bad_range   = (left_reg > right_reg) || (CNT_W'(right_reg) >= count_reg);
        cond.has_pair    = (count_reg != '0);
        cond.more_levels = (lvl_reg != LVL_W'(LEVELS - 1))
                           && (SPAN_W'(s_reg) >= (SPAN_W'(1) << lvl_reg));
    end

    // start of the next lower span one level up
    always_comb
    begin
        logic [SPAN_W-1:0] diff;
        diff   = SPAN_W'(s_reg) - (SPAN_W'(1) << lvl_reg);
        s_step = diff[IDX_W-1:0];
    end

    // datapath next values
    always_comb
    begin
        logic [CNT_W-1:0] cnt_dec;
        cnt_dec      = count_reg - CNT_W'(1);
        opcode_next  = ctl.load ? opcode      : opcode_reg;
        value_next   = ctl.load ? value       : value_reg;
        left_next    = ctl.load ? left_index  : left_reg;
        right_next   = ctl.load ? right_index : right_reg;
        lvl_next     = lvl_reg;
        s_next       = s_reg;
        carry_next   = carry_reg;
        q2_addr_next = q2_addr_reg;
        if (ctl.append_init)
        begin
            lvl_next   = LVL_W'(1);
            s_next     = cnt_dec[IDX_W-1:0];
            carry_next = value_reg;
        end
        else if (ctl.append_step)
        begin
            lvl_next   = lvl_reg + LVL_W'(1);
            s_next     = s_step;
            carry_next = min_val;
        end
        else if (ctl.query_second)
        begin
            carry_next = rd_data;
        end
        if (ctl.query_first)
        begin
            q2_addr_next = tbl_addr(q_lvl, second_idx);
        end
    end

    // table memory access
    always_comb
    begin
        wr_en = ctl.append_init | ctl.append_step;
        if (ctl.append_init)
        begin
            wr_addr = tbl_addr('0, count_reg[IDX_W-1:0]);
            wr_data = value_reg;
        end
        else
        begin
            wr_addr = tbl_addr(lvl_reg, s_reg);
            wr_data = min_val;
        end
        rd_en = ctl.append_read | ctl.query_first | ctl.query_second;
        priority if (ctl.append_read)
        begin
            rd_addr = tbl_addr(ctl.append_init ? LVL_W'(0) : lvl_reg, s_next);
        end
        else if (ctl.query_first)
        begin
            rd_addr = tbl_addr(q_lvl, left_reg);
        end
        else
        begin
            rd_addr = q2_addr_reg;
        end
    end

    // result and count next values
    always_comb
    begin
        done_next   = ctl.finish;
        min_next    = min_reg;
        status_next = status_reg;
        count_next  = count_reg;
        if (ctl.finish)
        begin
            min_next    = ctl.take_min ? min_val : '0;
            status_next = ctl.status;
            unique case (ctl.cnt_op)
                CNT_KEEP: count_next = count_reg;
                CNT_ZERO: count_next = '0;
                CNT_INC:  count_next = count_reg + CNT_W'(1);
                default:  count_next = count_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        opcode_reg  <= opcode_next;
        value_reg   <= value_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        lvl_reg     <= lvl_next;
        s_reg       <= s_next;
        carry_reg   <= carry_next;
        q2_addr_reg <= q2_addr_next;
        min_reg     <= min_next;
        status_reg  <= status_next;
    end

    assign busy         = ctl.busy;
    assign done         = done_reg;
    assign minimum      = min_reg;
    assign status       = status_reg;
    assign stored_count = count_reg;

endmodule

FILE: tb/sparse_table_range_minimum_test.sv
module sparse_table_range_minimum_test;
    import stmq_pkg::*;

    localparam int CAP   = CAPACITY_DEF;
    localparam int LVL   = LEVELS_DEF;
    localparam int VB    = VALUE_BITS_DEF;
    localparam int IDX_W = $clog2(CAP);
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int IDLE_LIMIT = 500;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [VB-1:0] VAL_MIN = {1'b1, {(VB-1){1'b0}}};
    localparam logic signed [VB-1:0] VAL_MAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic [IDX_W-1:0] IDX_TOP = {IDX_W{1'b1}};

    // one operation, with its result typed in where it is obvious
    typedef struct packed {
        logic [1:0]           op;
        logic signed [VB-1:0] val;
        logic [IDX_W-1:0]     lft;
        logic [IDX_W-1:0]     rgt;
        logic                 typed;
        logic signed [VB-1:0] min_v;
        logic [1:0]           st;
        logic [CNT_W-1:0]     cnt;
    } op_row_t;

    typedef struct packed {
        logic signed [VB-1:0] min_v;
        logic [1:0]           st;
        logic [CNT_W-1:0]     cnt;
    } rmq_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [1:0]           opcode = OP_CLEAR;
    logic signed [VB-1:0] value = '0;
    logic [IDX_W-1:0]     left_index = '0;
    logic [IDX_W-1:0]     right_index = '0;
    logic                 busy;
    logic                 done;
    logic signed [VB-1:0] minimum;
    logic [1:0]           status;
    logic [CNT_W-1:0]     stored_count;

    // shadow of the table and element count
    logic signed [VB-1:0] level_min [LVL][CAP];
    int                   held_count = 0;

    op_row_t     op_list[$];
    rmq_result_t expected_results[$];
    int          gen_count = 0;
    int          fail_count = 0;
    int          idle_cycles = 0;

    // directed rows: extremes, every opcode, bad ranges, clear
    op_row_t directed_rows [24] = '{
        '{OP_QUERY,  '0,      '0,      '0,      1'b1, '0,      ST_BAD_RANGE, 11'd0},
        '{OP_UNUSED, '0,      '0,      '0,      1'b1, '0,      ST_OK,        11'd0},
        '{OP_APPEND, VAL_MIN, '0,      '0,      1'b1, '0,      ST_OK,        11'd1},
        '{OP_APPEND, VAL_MAX, '0,      '0,      1'b1, '0,      ST_OK,        11'd2},
        '{OP_APPEND, 32'sd0,  '0,      '0,      1'b1, '0,      ST_OK,        11'd3},
        '{OP_APPEND, -32'sd1, '0,      '0,      1'b1, '0,      ST_OK,        11'd4},
        '{OP_APPEND, 32'sd1,  '0,      '0,      1'b1, '0,      ST_OK,        11'd5},
        '{OP_APPEND, 32'sh55555555, '0, '0,     1'b1, '0,      ST_OK,        11'd6},
        '{OP_APPEND, 32'shAAAAAAAA, '0, '0,     1'b1, '0,      ST_OK,        11'd7},
        '{OP_APPEND, 32'sd100, '0,     '0,      1'b1, '0,      ST_OK,        11'd8},
        '{OP_QUERY,  '0,      10'd0,   10'd0,   1'b1, VAL_MIN, ST_OK,        11'd8},
        '{OP_QUERY,  '0,      10'd1,   10'd1,   1'b1, VAL_MAX, ST_OK,        11'd8},
        '{OP_QUERY,  '0,      10'd1,   10'd7,   1'b0, '0,      ST_OK,        11'd0},
        '{OP_QUERY,  '0,      10'd0,   10'd7,   1'b1, VAL_MIN, ST_OK,        11'd8},
        '{OP_QUERY,  '0,      10'd2,   10'd3,   1'b0, '0,      ST_OK,        11'd0},
        '{OP_QUERY,  '0,      10'd3,   10'd2,   1'b1, '0,      ST_BAD_RANGE, 11'd8},
        '{OP_QUERY,  '0,      10'd0,   10'd8,   1'b1, '0,      ST_BAD_RANGE, 11'd8},
        '{OP_QUERY,  '0,      IDX_TOP, IDX_TOP, 1'b1, '0,      ST_BAD_RANGE, 11'd8},
        '{OP_QUERY,  '0,      10'd4,   10'd7,   1'b0, '0,      ST_OK,        11'd0},
        '{OP_UNUSED, -32'sd1, IDX_TOP, IDX_TOP, 1'b1, '0,      ST_OK,        11'd8},
        '{OP_CLEAR,  '0,      '0,      '0,      1'b1, '0,      ST_OK,        11'd0},
        '{OP_QUERY,  '0,      10'd0,   10'd0,   1'b1, '0,      ST_BAD_RANGE, 11'd0},
        '{OP_APPEND, 32'sd7,  '0,      '0,      1'b1, '0,      ST_OK,        11'd1},
        '{OP_QUERY,  '0,      10'd0,   10'd0,   1'b1, 32'sd7,  ST_OK,        11'd1}
    };

    sparse_table_range_minimum u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .value        (value),
        .left_index   (left_index),
        .right_index  (right_index),
        .done         (done),
        .minimum      (minimum),
        .status       (status),
        .stored_count (stored_count)
    );

    always #6 clk = ~clk;

    // update the shadow table and work out the result of one operation
    function automatic rmq_result_t rmq_predict(input logic [1:0] op,
                                                input logic signed [VB-1:0] val,
                                                input logic [IDX_W-1:0] lft,
                                                input logic [IDX_W-1:0] rgt);
        rmq_result_t r;
        int k;
        int span;
        int s;
        int len;
        int second;
        logic signed [VB-1:0] a;
        logic signed [VB-1:0] b;
        r = '0;
        r.st = ST_OK;
        case (op)
            OP_CLEAR: held_count = 0;
            OP_APPEND:
            begin
                if (held_count >= CAP)
                    r.st = ST_FULL;
                else
                begin
                    level_min[0][held_count] = val;
                    for (k = 1; k < LVL; k++)
                    begin
                        span = 1 << k;
                        if (held_count + 1 < span)
                            break;
                        s = held_count + 1 - span;
                        a = level_min[k-1][s];
                        b = level_min[k-1][s + span/2];
                        level_min[k][s] = (a < b) ? a : b;
                    end
                    held_count++;
                end
            end
            OP_QUERY:
            begin
                if (int'(lft) > int'(rgt) || int'(rgt) >= held_count)
                    r.st = ST_BAD_RANGE;
                else
                begin
                    len = int'(rgt) - int'(lft) + 1;
                    k = 0;
                    while (len > 1)
                    begin
                        len = len >> 1;
                        k++;
                    end
                    if (k > LVL - 1)
                        k = LVL - 1;
                    second = int'(rgt) + 1 - (1 << k);
                    a = level_min[k][lft];
                    b = level_min[k][second];
                    r.min_v = (a < b) ? a : b;
                end
            end
            default: ;
        endcase
        r.cnt = held_count[CNT_W-1:0];
        return r;
    endfunction

    // queue one operation whose result comes from the predictor
    function automatic void add_op(input logic [1:0] op, input logic signed [VB-1:0] val,
                                   input logic [IDX_W-1:0] lft, input logic [IDX_W-1:0] rgt);
        op_row_t row;
        row = '0;
        row.op = op;
        row.val = val;
        row.lft = lft;
        row.rgt = rgt;
        op_list = {op_list, row};
        if (op == OP_CLEAR)
            gen_count = 0;
        else if (op == OP_APPEND && gen_count < CAP)
            gen_count++;
    endfunction

    // append value: full range or small values that produce ties
    function automatic logic signed [VB-1:0] rand_value();
        if ($urandom_range(0, 3) == 0)
            return $signed($urandom_range(0, 15)) - 8;
        return $urandom;
    endfunction

    // query inside the held elements, sometimes of power-of-two length
    function automatic void add_valid_query();
        int r;
        int l;
        int k;
        int len;
        if ($urandom_range(0, 3) == 0)
        begin
            k = 0;
            while ((2 << k) <= gen_count)
                k++;
            len = 1 << $urandom_range(0, k);
            l = $urandom_range(0, gen_count - len);
            r = l + len - 1;
        end
        else
        begin
            r = $urandom_range(0, gen_count - 1);
            l = $urandom_range(0, r);
        end
        add_op(OP_QUERY, $urandom, l[IDX_W-1:0], r[IDX_W-1:0]);
    endfunction

    // random mix of operations
    function automatic void add_random_ops(input int n);
        int i;
        int pick;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                add_op(OP_CLEAR, $urandom, IDX_W'($urandom), IDX_W'($urandom));
            else if (pick < 4)
                add_op(OP_UNUSED, $urandom, IDX_W'($urandom), IDX_W'($urandom));
            else if (pick < 50)
                add_op(OP_APPEND, rand_value(), IDX_W'($urandom), IDX_W'($urandom));
            else if (gen_count > 0 && $urandom_range(0, 99) < 85)
                add_valid_query();
            else
                add_op(OP_QUERY, $urandom, IDX_W'($urandom), IDX_W'($urandom));
        end
    endfunction

    // check each result strobe against the oldest expectation
    always @(posedge clk)
    begin
        rmq_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: minimum %0d status %0d count %0d",
                       minimum, status, stored_count);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (minimum !== want.min_v)
                begin
                    $error("minimum mismatch: expected %0d, got %0d", want.min_v, minimum);
                    fail_count++;
                end
                if (status !== want.st)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.st, status);
                    fail_count++;
                end
                if (stored_count !== want.cnt)
                begin
                    $error("stored_count mismatch: expected %0d, got %0d",
                           want.cnt, stored_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // build the stimulus, release reset, drive transfers in bursts
    initial
    begin
        op_row_t     row;
        rmq_result_t pred;
        int          burst_left;
        int          gap;
        int          i;
        for (i = 0; i < 24; i++)
        begin
            op_list = {op_list, directed_rows[i]};
            if (directed_rows[i].op == OP_CLEAR)
                gen_count = 0;
            else if (directed_rows[i].op == OP_APPEND)
                gen_count++;
        end
        add_random_ops(263);
        add_random_ops(263);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        gap = 0;
        while (op_list.size() > 0)
        begin
            row = op_list.pop_front();
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
            else
                gap = 0;
            burst_left--;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            opcode <= row.op;
            value <= row.val;
            left_index <= row.lft;
            right_index <= row.rgt;
            start <= 1'b1;
            // hold until the block takes the transfer
            do
                @(posedge clk);
            while (busy);
            pred = rmq_predict(row.op, row.val, row.lft, row.rgt);
            if (row.typed)
            begin
                pred.min_v = row.min_v;
                pred.st = row.st;
                pred.cnt = row.cnt;
            end
            expected_results = {expected_results, pred};
        end
        start <= 1'b0;

        // drain, then allow for a stray strobe
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
